// File: sv/equidepth_histogram_bin_lookup_macros.svh
// Assertion macros for the equi-depth histogram bin lookup block.
// Used by equidepth_histogram_bin_lookup.sv; expects clk and rst_n in scope.
`ifndef EQUIDEPTH_HISTOGRAM_BIN_LOOKUP_MACROS_SVH
`define EQUIDEPTH_HISTOGRAM_BIN_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define EHBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that implies a consequence in the next cycle.
`define EHBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EHBL_ASSERT(lbl, prop, msg)
`define EHBL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/ehbl_pkg.sv
// Package for the equi-depth histogram bin lookup block: sizes, codes, states.
// No dependencies.
`timescale 1ns / 1ps
package ehbl_pkg;
    localparam int MAX_BINS   = 1024;
    localparam int SPLIT_AW   = $clog2(MAX_BINS);
    localparam int CNT_W      = SPLIT_AW + 1;
    localparam int KEY_W      = 64;
    localparam int BIN_W      = 10;
    localparam int OUT_TDATA_W = ((BIN_W + 7) / 8) * 8;
    localparam int BIN_CFG_W  = 11;
    localparam int KPB_W      = 32;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_TRAIN = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_BIN_COUNT    = 1'b0;
    localparam logic CFG_KEYS_PER_BIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } ehbl_state_t;
endpackage

// File: sv/equidepth_histogram_bin_lookup.sv
// Equi-depth histogram bin lookup: split table training and upper-bound search.
// Depends on ehbl_pkg and equidepth_histogram_bin_lookup_macros.svh.
//
// Usage:
//   Input stream s_*: s_tdata carries the 64-bit key, s_tuser the op
//   (0 = training key in sorted order, 1 = query). Output stream m_*:
//   m_tdata[9:0] carries the bin index of a query; training gives nothing.
//   Config port: cfg_we/cfg_index/cfg_data, index 0 = bin count,
//   index 1 = keys_per_bin; write only while the block is idle.
// Sequence:
//   A training request is taken in the idle state. A query is taken in the
//   idle state, makes one binary-search probe of the split memory per
//   search step (up to ceil(log2(n+1)) probes for n stored splits, 11 at
//   1024 splits) and then loads the output register in the finish state.
//   Each probe is one read of the split memory, whose registered read data
//   feeds the compare that picks the next address.
// Reset clears the split count, the group phase and the output valid;
// the bin count and keys_per_bin return to 1. If the receiver stalls, the result
// holds in the output register; training requests are still taken, and a
// new query finishes its search and waits until the output register frees.
`timescale 1ns / 1ps
`include "equidepth_histogram_bin_lookup_macros.svh"
module equidepth_histogram_bin_lookup (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ehbl_pkg::KEY_W-1:0]        s_tdata,   // [63:0] key
    input  logic                              s_tuser,   // [0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ehbl_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [9:0] bin_index, rest zero
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ehbl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ehbl_pkg::*;

    // split memory
    logic [KEY_W-1:0]    split_mem [MAX_BINS];
    logic [KEY_W-1:0]    rd_data_reg;
    logic [SPLIT_AW-1:0] raddr;
    logic                mem_we;

    ehbl_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    split_count_reg, split_count_next;
    logic [KPB_W-1:0]    phase_reg, phase_next;
    logic [BIN_CFG_W-1:0] bin_cfg_reg;
    logic [KPB_W-1:0]    kpb_reg;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;

    logic [CNT_W-1:0]    half, probe, srch_lo, srch_n, rd_sum, limit, res_cnt;
    logic                hit, capture, out_free, group_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(bin_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            split_mem[split_count_reg[SPLIT_AW-1:0]] <= s_tdata;
        end
        rd_data_reg <= split_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cfg_reg <= BIN_CFG_W'(1);
            kpb_reg     <= KPB_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIN_COUNT:    bin_cfg_reg <= cfg_data[BIN_CFG_W-1:0];
                CFG_KEYS_PER_BIN: kpb_reg     <= cfg_data[KPB_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            split_count_reg <= '0;
            phase_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            split_count_reg <= split_count_next;
            phase_reg       <= phase_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        n_reg   <= n_next;
        key_reg <= key_next;
        bin_reg <= bin_next;
    end

    // one search step: compare the probe read last cycle, narrow the range
    assign half    = n_reg >> 1;
    assign probe   = lo_reg + half;
    assign hit     = (rd_data_reg <= key_reg);
    assign srch_lo = hit ? probe + CNT_W'(1) : lo_reg;
    assign srch_n  = hit ? n_reg - half - CNT_W'(1) : half;

    assign limit     = (bin_cfg_reg > BIN_CFG_W'(MAX_BINS)) ? CNT_W'(MAX_BINS)
                                                            : CNT_W'(bin_cfg_reg);
    assign capture   = (phase_reg == '0) && (split_count_reg < limit);
    assign group_end = (kpb_reg == '0) || (phase_reg >= kpb_reg - KPB_W'(1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign res_cnt   = (lo_reg == '0) ? '0 : lo_reg - CNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        split_count_next = split_count_reg;
        phase_next       = phase_reg;
        lo_next          = lo_reg;
        n_next           = n_reg;
        key_next         = key_reg;
        bin_next         = bin_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        mem_we           = 1'b0;
        rd_sum           = probe;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_TRAIN)
                    begin
                        if (capture)
                        begin
                            mem_we           = 1'b1;
                            split_count_next = split_count_reg + CNT_W'(1);
                        end
                        phase_next = group_end ? '0 : phase_reg + KPB_W'(1);
                    end
                    else
                    begin
                        key_next   = s_tdata;
                        lo_next    = '0;
                        n_next     = split_count_reg;
                        rd_sum     = split_count_reg >> 1;
                        state_next = (split_count_reg == '0) ? ST_FINISH : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                lo_next = srch_lo;
                n_next  = srch_n;
                rd_sum  = srch_lo + (srch_n >> 1);
                if (srch_n == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    bin_next      = res_cnt[BIN_W-1:0];
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        raddr = rd_sum[SPLIT_AW-1:0];
    end

    `EHBL_ASSERT(a_count_limit, split_count_reg <= CNT_W'(MAX_BINS), "split count above table size")
    `EHBL_ASSERT(a_search_range,
        (state_reg != ST_SEARCH) || ((n_reg != '0) && (lo_reg + n_reg <= split_count_reg)),
        "search range outside stored splits")
    `EHBL_ASSERT_NEXT(a_count_step, mem_we,
        split_count_reg == $past(split_count_reg) + CNT_W'(1), "split write without count step")
    `EHBL_ASSERT(a_result_src, !$rose(m_tvalid_reg) || ($past(state_reg) == ST_FINISH),
        "result raised outside finish")
    `EHBL_ASSERT(a_write_idle, !mem_we || (state_reg == ST_IDLE), "split write during search")
endmodule

// File: test/tb_equidepth_histogram_bin_lookup.sv
`timescale 1ns / 1ps
// Testbench for equidepth_histogram_bin_lookup: trains the split table with sorted keys and
// checks every query's bin index against a split-table predictor held in a scoreboard class.
// Depends on ehbl_pkg and the block's RTL.

module tb_equidepth_histogram_bin_lookup;
    import ehbl_pkg::*;

    class bin_scoreboard;
        logic [KEY_W-1:0] splits [MAX_BINS];
        int unsigned      split_cnt;
        int unsigned      group_pos;
        int unsigned      nbins;
        int unsigned      kpb;
        logic [BIN_W-1:0] expected_bins [$];
        int unsigned      mismatches;

        function new();
            split_cnt  = 0;
            group_pos  = 0;
            nbins      = 1;
            kpb        = 1;
            mismatches = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_BIN_COUNT)
                nbins = int'(val[BIN_CFG_W-1:0]);
            else
                kpb = val[KPB_W-1:0];
        endfunction

        // Upper-bound halving over the stored splits, same probe order as the block
        function logic [BIN_W-1:0] predict_bin(logic [KEY_W-1:0] key);
            int unsigned lo;
            int unsigned n;
            int unsigned half;
            int unsigned probe;
            lo = 0;
            n  = split_cnt;
            while (n > 0)
            begin
                half  = n / 2;
                probe = lo + half;
                if (splits[probe] <= key)
                begin
                    lo = probe + 1;
                    n  = n - half - 1;
                end
                else
                    n = half;
            end
            return (lo == 0) ? '0 : BIN_W'(lo - 1);
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key);
            int unsigned limit;
            if (op == OP_QUERY)
                expected_bins.insert(expected_bins.size(), predict_bin(key));
            else
            begin
                limit = (nbins > MAX_BINS) ? MAX_BINS : nbins;
                if (group_pos == 0 && split_cnt < limit)
                begin
                    splits[split_cnt] = key;
                    split_cnt++;
                end
                if (kpb == 0 || group_pos >= kpb - 1)
                    group_pos = 0;
                else
                    group_pos++;
            end
        endfunction

        function void check_response(logic [OUT_TDATA_W-1:0] data);
            logic [BIN_W-1:0] want;
            if (expected_bins.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result %0d with no query pending", $time, data[BIN_W-1:0]);
                mismatches++;
                return;
            end
            want = expected_bins.pop_front();
            if (data[BIN_W-1:0] !== want)
            begin
                if (mismatches < 10)
                    $display("%0t: bin_index mismatch: expected %0d, got %0d",
                             $time, want, data[BIN_W-1:0]);
                mismatches++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 11;
    localparam int FILL_ITEMS     = 40;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [KEY_W-1:0]       s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    bin_scoreboard sb = new();

    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      hold_req       = 0;
    int unsigned      hold_left      = 0;
    int unsigned      quiet_cycles   = 0;
    logic [KEY_W-1:0] key_run        = '0;

    equidepth_histogram_bin_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Result side: check, then decide tready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata);
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(logic op, logic [KEY_W-1:0] key);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, key);
    endtask

    // Sender stops until every query has answered, then lets the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_bins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] nb, logic [CFG_DATA_W-1:0] kp);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BIN_COUNT;
        cfg_data  <= nb;
        @(posedge clk);
        sb.write_reg(CFG_BIN_COUNT, nb);
        cfg_index <= CFG_KEYS_PER_BIN;
        cfg_data  <= kp;
        @(posedge clk);
        sb.write_reg(CFG_KEYS_PER_BIN, kp);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] next_sorted_key();
        logic [KEY_W-1:0] stride;
        stride  = {$urandom, $urandom} >> $urandom_range(12, 63);
        key_run = key_run + stride;
        return key_run;
    endfunction

    // Mostly keys on or next to a stored split, where the compare flips
    function automatic logic [KEY_W-1:0] pick_query_key();
        int unsigned sel;
        int unsigned idx;
        sel = $urandom_range(0, 9);
        if (sb.split_cnt != 0 && sel < 6)
        begin
            idx = $urandom_range(0, sb.split_cnt - 1);
            return sb.splits[idx] + KEY_W'($urandom_range(0, 2)) - 64'd1;
        end
        else if (sel < 8)
            return {$urandom, $urandom} % (key_run + 64'd1);
        else if (sel == 8)
            return {$urandom, $urandom};
        else
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bin_count();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 1024;
            3: return 2047;
            4, 5: return $urandom_range(0, 2047);
            default: return $urandom_range(1, 1024);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_keys_per_bin();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3, 4, 5: return 1;
            default: return $urandom_range(2, 5);
        endcase
    endfunction

    task automatic run_random_burst(int unsigned count);
        int unsigned r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_item(OP_TRAIN, next_sorted_key());
            else if (r < 92)
                send_item(OP_QUERY, pick_query_key());
            else if (r < 96)
                send_item(OP_TRAIN, {$urandom, $urandom});   // out-of-order key
            else
                send_item(OP_QUERY, {$urandom, $urandom});
        end
    endtask

    task automatic set_idle_mode(int unsigned mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 47;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 47;
            end
            default:
            begin
                send_idle_pct  = 11;
                recv_stall_pct = 11;
            end
        endcase
    endtask

    initial
    begin
        int unsigned p;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, reset settings
        send_item(OP_QUERY, '0);
        send_item(OP_QUERY, '1);

        // No bins, zero keys per bin: nothing captured
        set_config(0, 0);
        send_item(OP_TRAIN, 64'd5);
        send_item(OP_TRAIN, 64'd7);
        send_item(OP_QUERY, 64'd6);

        // Three bins: the fourth key hits the split limit
        set_config(3, 1);
        send_item(OP_TRAIN, 64'd10);
        send_item(OP_TRAIN, 64'd100);
        send_item(OP_TRAIN, 64'd200);
        send_item(OP_TRAIN, 64'd300);
        send_item(OP_QUERY, 64'd9);
        send_item(OP_QUERY, 64'd10);
        send_item(OP_QUERY, 64'd100);
        send_item(OP_QUERY, 64'd199);
        send_item(OP_QUERY, '1);

        // Huge group size, then shrink it mid-group so the phase wraps
        set_config(2047, 32'hFFFF_FFFF);
        send_item(OP_TRAIN, 64'd400);
        send_item(OP_TRAIN, 64'd500);
        send_item(OP_QUERY, 64'd450);
        set_config(2047, 2);
        send_item(OP_TRAIN, 64'd600);
        send_item(OP_TRAIN, 64'd700);
        send_item(OP_QUERY, 64'd700);
        send_item(OP_QUERY, 64'h8000_0000_0000_0000);
        key_run = 64'd700;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 4)
                wait_drained();
            else if (p % 3 == 0)
                set_config(2047, 1);
            else
                set_config(pick_bin_count(), pick_keys_per_bin());
            set_idle_mode(p);
            if (p == 6)
            begin
                // long receiver hold-off while queries keep coming
                hold_req = HOLD_CYCLES;
                repeat (12)
                    send_item(OP_QUERY, pick_query_key());
            end
            run_random_burst(PHASE_ITEMS);
        end

        // Top up the table with more splits, then search it
        set_config(2047, 1);
        set_idle_mode(0);
        repeat (FILL_ITEMS)
            send_item(OP_TRAIN, next_sorted_key());
        set_idle_mode(3);
        repeat (30)
            send_item(OP_QUERY, pick_query_key());
        send_item(OP_QUERY, '1);

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_bins.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
